[rtl/bmhq_pkg.sv]
`default_nettype none

package bmhq_pkg;

    // opcode carried on the input tuser
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // result status carried on the output tuser
    typedef logic [1:0] t_status;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_UNDERFLOW = 2'd1;
    localparam t_status ST_OVERFLOW  = 2'd2;

    localparam int unsigned KEY_PORT_W = 32;

endpackage

`default_nettype wire

[rtl/binary_max_heap_queue_unit.sv]
// Channel    Dir  tdata                                    tuser
// s_axis     in   [31:0] key_value                         [0] operation
// m_axis     out  [31:0] popped_key, [CW+31:32] entry_cnt  [1:0] status
//
// One transaction at a time. A push moves the hole up one level per step; a pop sinks
// the moved key one level per step, reading each child in turn
// (both child reads share the one RAM read port).
// The result sits in an output register; the next transaction can start while it
// waits. Synchronous active-low reset clears count and control; heap RAM contents
// are not reset (only entries below the count are used).
`default_nettype none

module binary_max_heap_queue_unit
    import bmhq_pkg::*;
#(
    parameter int unsigned CAPACITY  = 32,
    parameter int unsigned KEY_WIDTH = 32,
    localparam int unsigned AW       = $clog2(CAPACITY),
    localparam int unsigned CW       = $clog2(CAPACITY + 1),
    localparam int unsigned OUT_DW   = ((KEY_PORT_W + CW + 7) / 8) * 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [KEY_PORT_W-1:0] s_axis_tdata,   // [31:0] key_value
    input  wire logic                  s_axis_tuser,   // [0] operation

    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DW-1:0]          m_axis_tdata,   // [31:0] popped_key, [CW+31:32] count
    output logic [1:0]                 m_axis_tuser    // [1:0] status
);

    localparam int unsigned LW = AW + 2;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_UP_CHK = 4'd1;
    localparam logic [3:0] S_UP_CMP = 4'd2;
    localparam logic [3:0] S_POP_R0 = 4'd3;
    localparam logic [3:0] S_POP_RL = 4'd4;
    localparam logic [3:0] S_POP_CP = 4'd5;
    localparam logic [3:0] S_DN_CHK = 4'd6;
    localparam logic [3:0] S_DN_RR  = 4'd7;
    localparam logic [3:0] S_DN_CMP = 4'd8;
    localparam logic [3:0] S_FIN    = 4'd9;

    logic [3:0]           r_state, n_state;
    logic [AW-1:0]        r_pos, n_pos;
    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic [KEY_WIDTH-1:0] r_lv, n_lv;
    logic [KEY_WIDTH-1:0] r_pop, n_pop;
    logic [CW-1:0]        r_cnt, n_cnt;
    t_status              r_st, n_st;
    logic                 r_ov, n_ov;
    logic [OUT_DW-1:0]    r_odata, n_odata;
    logic [1:0]           r_ouser, n_ouser;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [KEY_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [KEY_WIDTH-1:0] ram_rdata;

    logic [LW-1:0]        lc_x, rc_x, cnt_x;
    logic [AW-1:0]        parent;
    logic                 use_r;
    logic [KEY_WIDTH-1:0] best_v;
    logic [AW-1:0]        best_i;

    bmhq_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (CAPACITY)
    ) u_heap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign lc_x   = LW'({r_pos, 1'b1});
    assign rc_x   = lc_x + LW'(1);
    assign cnt_x  = LW'(r_cnt);
    assign parent = (r_pos - AW'(1)) >> 1;

    // right child wins only when present and strictly larger; ties go left
    assign use_r  = (rc_x < cnt_x) && ($signed(ram_rdata) > $signed(r_lv));
    assign best_v = use_r ? ram_rdata : r_lv;
    assign best_i = use_r ? rc_x[AW-1:0] : lc_x[AW-1:0];

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_key     = r_key;
        n_lv      = r_lv;
        n_pop     = r_pop;
        n_cnt     = r_cnt;
        n_st      = r_st;
        n_ov      = r_ov && !m_axis_tready;
        n_odata   = r_odata;
        n_ouser   = r_ouser;
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = r_key;
        ram_raddr = parent;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_pop = '0;
                    n_st  = ST_OK;
                    if (s_axis_tuser == OP_PUSH) begin
                        if (r_cnt == CW'(CAPACITY)) begin
                            n_st    = ST_OVERFLOW;
                            n_state = S_FIN;
                        end else begin
                            n_key   = KEY_WIDTH'(signed'(s_axis_tdata));
                            n_pos   = r_cnt[AW-1:0];
                            n_cnt   = r_cnt + CW'(1);
                            n_state = S_UP_CHK;
                        end
                    end else begin
                        if (r_cnt == '0) begin
                            n_st    = ST_UNDERFLOW;
                            n_state = S_FIN;
                        end else begin
                            n_state = S_POP_R0;
                        end
                    end
                end
            end
            S_UP_CHK: begin
                ram_raddr = parent;
                if (r_pos == '0) begin
                    ram_we  = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                ram_we = 1'b1;
                if ($signed(ram_rdata) < $signed(r_key)) begin
                    // parent drops into the hole, hole moves up
                    ram_wdata = ram_rdata;
                    n_pos     = parent;
                    n_state   = S_UP_CHK;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_POP_R0: begin
                ram_raddr = '0;
                n_state   = S_POP_RL;
            end
            S_POP_RL: begin
                ram_raddr = AW'(r_cnt - CW'(1));
                n_pop     = ram_rdata;
                n_state   = S_POP_CP;
            end
            S_POP_CP: begin
                n_key   = ram_rdata;
                n_cnt   = r_cnt - CW'(1);
                n_pos   = '0;
                n_state = S_DN_CHK;
            end
            S_DN_CHK: begin
                ram_raddr = lc_x[AW-1:0];
                if (lc_x >= cnt_x) begin
                    ram_we  = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_state = S_DN_RR;
                end
            end
            S_DN_RR: begin
                // rc may equal the count here; its data is then ignored
                ram_raddr = rc_x[AW-1:0];
                n_lv      = ram_rdata;
                n_state   = S_DN_CMP;
            end
            S_DN_CMP: begin
                ram_we = 1'b1;
                if ($signed(best_v) > $signed(r_key)) begin
                    ram_wdata = best_v;
                    n_pos     = best_i;
                    n_state   = S_DN_CHK;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_ov || m_axis_tready) begin
                    n_ov    = 1'b1;
                    n_odata = OUT_DW'({r_cnt, KEY_PORT_W'(signed'(r_pop))});
                    n_ouser = r_st;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
        r_pos   <= n_pos;
        r_key   <= n_key;
        r_lv    <= n_lv;
        r_pop   <= n_pop;
        r_st    <= n_st;
        r_odata <= n_odata;
        r_ouser <= n_ouser;
    end

endmodule

`default_nettype wire

[rtl/bmhq_ram.sv]
`default_nettype none

module bmhq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

[sim/binary_max_heap_queue_unit_tb.sv]
`timescale 1ns / 100ps

module binary_max_heap_queue_unit_tb;
    import bmhq_pkg::*;

    localparam int unsigned CAP   = 32;
    localparam int unsigned CNT_W = $clog2(CAP + 1);
    localparam int unsigned OUT_W = ((KEY_PORT_W + CNT_W + 7) / 8) * 8;
    localparam int unsigned N_RANDOM = 750;
    localparam int unsigned N_DIR    = 20;

    typedef struct packed {
        t_status          st;
        logic [31:0]      key;
        logic [CNT_W-1:0] cnt;
    } heap_result;

    typedef struct {
        logic        op;
        logic [31:0] key;
        bit          known;
        heap_result  res;
    } op_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [KEY_PORT_W-1:0]   s_axis_tdata = '0;   // [31:0] key_value
    logic                    s_axis_tuser = OP_PUSH;   // [0] operation
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_W-1:0]        m_axis_tdata;   // [31:0] popped_key, [37:32] entry_count
    logic [1:0]              m_axis_tuser;   // [1:0] status

    binary_max_heap_queue_unit #(
        .CAPACITY  (CAP),
        .KEY_WIDTH (32)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // mirror of the heap, updated once per accepted transaction
    int          heap_mirror [CAP];
    int unsigned keys_held = 0;
    heap_result  pending_results [$];
    int unsigned err_cnt = 0;
    bit          quiet = 1'b0;   // no gaps on either side while set
    int unsigned rx_hold = 0;

    function automatic heap_result heap_apply(logic op, logic [31:0] key);
        heap_result  r;
        int unsigned pos;
        int unsigned up;
        int unsigned lc;
        int unsigned best;
        int          t;
        r.st  = ST_OK;
        r.key = '0;
        if (op == OP_PUSH) begin
            if (keys_held >= CAP) begin
                r.st = ST_OVERFLOW;
            end else begin
                pos = keys_held;
                heap_mirror[pos] = key;
                keys_held++;
                while (pos > 0) begin
                    up = (pos - 1) >> 1;
                    if (heap_mirror[up] >= heap_mirror[pos]) break;
                    t = heap_mirror[up];
                    heap_mirror[up] = heap_mirror[pos];
                    heap_mirror[pos] = t;
                    pos = up;
                end
            end
        end else begin
            if (keys_held == 0) begin
                r.st = ST_UNDERFLOW;
            end else begin
                r.key = heap_mirror[0];
                keys_held--;
                heap_mirror[0] = heap_mirror[keys_held];
                pos = 0;
                while (1) begin
                    lc = 2 * pos + 1;
                    if (lc >= keys_held) break;
                    best = lc;
                    // left child wins a tie
                    if (lc + 1 < keys_held && heap_mirror[lc + 1] > heap_mirror[lc])
                        best = lc + 1;
                    if (heap_mirror[best] <= heap_mirror[pos]) break;
                    t = heap_mirror[best];
                    heap_mirror[best] = heap_mirror[pos];
                    heap_mirror[pos] = t;
                    pos = best;
                end
            end
        end
        r.cnt = keys_held[CNT_W-1:0];
        return r;
    endfunction

    // mostly short, a few long
    function automatic int unsigned idle_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned send_gap();
        if (quiet || $urandom_range(0, 1) == 0) return 0;
        return idle_span();
    endfunction

    function automatic logic [31:0] draw_key(int unsigned mode);
        logic [31:0] k;
        case (mode)
            0: k = $urandom;
            1: k = $urandom_range(0, 8) - 4;   // narrow range, lots of equal keys
            2: begin
                case ($urandom_range(0, 4))
                    0: k = 32'h7FFF_FFFF;
                    1: k = 32'h8000_0000;
                    2: k = 32'hFFFF_FFFF;
                    3: k = 32'h0000_0000;
                    default: k = 32'h0000_0001;
                endcase
            end
            default: k = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 8) - 4;
        endcase
        return k;
    endfunction

    task automatic send_item(input logic op, input logic [31:0] key, input bit known,
                             input heap_result typed);
        int unsigned gap;
        heap_result  predicted;
        gap = send_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = heap_apply(op, key);
        pending_results.insert(pending_results.size(), known ? typed : predicted);
    endtask

    task automatic drain_pending();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // receiver side: random backpressure and result checking
    always @(posedge i_clk) begin : result_check
        heap_result want;
        heap_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.st  = m_axis_tuser;
            got.key = m_axis_tdata[31:0];
            got.cnt = m_axis_tdata[32 +: CNT_W];
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction: status %0d key %0d count %0d",
                       got.st, $signed(got.key), got.cnt);
                err_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (got.st !== want.st) begin
                    $error("status: expected %0d, got %0d", want.st, got.st);
                    err_cnt++;
                end
                if (got.key !== want.key) begin
                    $error("popped_key: expected %0d, got %0d",
                           $signed(want.key), $signed(got.key));
                    err_cnt++;
                end
                if (got.cnt !== want.cnt) begin
                    $error("entry_count: expected %0d, got %0d", want.cnt, got.cnt);
                    err_cnt++;
                end
            end
        end
        if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            m_axis_tready <= 1'b0;
            rx_hold <= idle_span() - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    op_row dir_tab [N_DIR] = '{
        '{OP_POP,  32'h0000_0000, 1'b1, '{ST_UNDERFLOW, 32'h0000_0000, 6'd0}},
        '{OP_PUSH, 32'h7FFF_FFFF, 1'b1, '{ST_OK,        32'h0000_0000, 6'd1}},
        '{OP_PUSH, 32'h8000_0000, 1'b1, '{ST_OK,        32'h0000_0000, 6'd2}},
        '{OP_POP,  32'hFFFF_FFFF, 1'b1, '{ST_OK,        32'h7FFF_FFFF, 6'd1}},
        '{OP_POP,  32'h1234_5678, 1'b1, '{ST_OK,        32'h8000_0000, 6'd0}},
        '{OP_POP,  32'hFFFF_FFFF, 1'b1, '{ST_UNDERFLOW, 32'h0000_0000, 6'd0}},
        // equal keys, then a tie between two children on the way down
        '{OP_PUSH, 32'd10,        1'b0, '{ST_OK, 32'h0, 6'd0}},
        '{OP_PUSH, 32'd5,         1'b0, '{ST_OK, 32'h0, 6'd0}},
        '{OP_PUSH, 32'd5,         1'b0, '{ST_OK, 32'h0, 6'd0}},
        '{OP_PUSH, 32'd5,         1'b0, '{ST_OK, 32'h0, 6'd0}},
        '{OP_PUSH, 32'hFFFF_FFFF, 1'b0, '{ST_OK, 32'h0, 6'd0}},
        '{OP_PUSH, 32'd10,        1'b0, '{ST_OK, 32'h0, 6'd0}},
        '{OP_PUSH, 32'h0000_0000, 1'b0, '{ST_OK, 32'h0, 6'd0}},
        '{OP_POP,  32'h0000_0000, 1'b0, '{ST_OK, 32'h0, 6'd0}},
        '{OP_POP,  32'h5A5A_A5A5, 1'b0, '{ST_OK, 32'h0, 6'd0}},
        '{OP_POP,  32'h0000_0000, 1'b0, '{ST_OK, 32'h0, 6'd0}},
        '{OP_PUSH, 32'h8000_0000, 1'b0, '{ST_OK, 32'h0, 6'd0}},
        '{OP_PUSH, 32'h7FFF_FFFF, 1'b0, '{ST_OK, 32'h0, 6'd0}},
        '{OP_POP,  32'h0000_0000, 1'b0, '{ST_OK, 32'h0, 6'd0}},
        '{OP_POP,  32'h0000_0000, 1'b0, '{ST_OK, 32'h0, 6'd0}}
    };

    initial begin : stimulus
        int unsigned issued;
        int unsigned seg_len;
        int unsigned push_pct;
        int unsigned key_mode;
        logic        op;
        heap_result  none;
        none = '0;
        issued = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIR; i++)
            send_item(dir_tab[i].op, dir_tab[i].key, dir_tab[i].known, dir_tab[i].res);
        drain_pending();

        // segments with a push bias, so the heap swings between empty and full
        while (issued < N_RANDOM) begin
            seg_len  = $urandom_range(8, 64);
            case ($urandom_range(0, 4))
                0: push_pct = 95;
                1: push_pct = 75;
                2: push_pct = 50;
                3: push_pct = 25;
                default: push_pct = 5;
            endcase
            key_mode = $urandom_range(0, 3);
            quiet    = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < seg_len && issued < N_RANDOM; i++) begin
                op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
                send_item(op, draw_key(key_mode), 1'b0, none);
                issued++;
            end
            if ($urandom_range(0, 3) == 0)
                drain_pending();
        end
        quiet = 1'b0;
        drain_pending();
        repeat (40) @(posedge i_clk);
        if (err_cnt == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin : watchdog
        #1_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
rtl/bmhq_pkg.sv
rtl/bmhq_ram.sv
rtl/binary_max_heap_queue_unit.sv
sim/binary_max_heap_queue_unit_tb.sv
